/* rtl/fdp_pkg.sv */
// ----------------------------------------------------------------------------
// fdp_pkg
// Types, widths and helpers shared by the FP8 ReLU dot product core.
// ----------------------------------------------------------------------------
package fdp_pkg;

  localparam int FP8_W      = 8;
  localparam int MAG_W      = 4;
  localparam int EXP_W      = 4;
  localparam int MANT_W     = 3;
  localparam int SHIFT_W    = 5;
  localparam int PROD_W     = 36;
  localparam int ACC_W      = 44;
  localparam int SCALE_W    = 24;
  localparam int SCALE_LO_W = 12;
  localparam int SCALE_HI_W = SCALE_W - SCALE_LO_W;
  localparam int PART_W     = ACC_W + SCALE_LO_W;
  localparam int FULL_W     = ACC_W + SCALE_W;
  localparam int FRAC_W     = 16;
  localparam int SCORE_W    = 52;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
  localparam logic [EXP_W-1:0]   EXP_SUBNORM = EXP_W'(1);
  localparam logic [SHIFT_W-1:0] EXP_OFFSET  = SHIFT_W'(2);

  typedef struct packed {
    logic             neg;
    logic [EXP_W-1:0] ex;
    logic [MAG_W-1:0] mag;
  } fp8_dec_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic              last;
  } fdp_elem_t;

  typedef enum logic [3:0] {
    ST_ACC = 4'b0001,
    ST_MUL = 4'b0010,
    ST_ADD = 4'b0100,
    ST_OUT = 4'b1000
  } fdp_state_t;

  function automatic fp8_dec_t fp8_decode(input logic [FP8_W-1:0] b);
    fp8_dec_t d;
    d.neg = b[FP8_W-1];
    if (b[FP8_W-2:MANT_W] == '0) begin
      d.ex  = EXP_SUBNORM;
      d.mag = {1'b0, b[MANT_W-1:0]};
    end else begin
      d.ex  = b[FP8_W-2:MANT_W];
      d.mag = {1'b1, b[MANT_W-1:0]};
    end
    return d;
  endfunction

endpackage

/* rtl/fdp_in_if.sv */
// ----------------------------------------------------------------------------
// fdp_in_if
// Element channel: one q/k byte pair and the last-element flag per transfer.
// ----------------------------------------------------------------------------
interface fdp_in_if import fdp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FP8_W-1:0] q_byte;
  logic [FP8_W-1:0] k_byte;
  logic             last_element;

  modport source (output valid, q_byte, k_byte, last_element, input ready);
  modport sink   (input valid, q_byte, k_byte, last_element, output ready);
endinterface

/* rtl/fdp_out_if.sv */
// ----------------------------------------------------------------------------
// fdp_out_if
// Score channel: one scaled ReLU dot product per transfer.
// ----------------------------------------------------------------------------
interface fdp_out_if import fdp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;

  modport source (output valid, score, input ready);
  modport sink   (input valid, score, output ready);
endinterface

/* rtl/fdp_front.sv */
// ----------------------------------------------------------------------------
// fdp_front
// Decodes both FP8 E4M3 bytes, forms the exact product and clamps negatives.
// ----------------------------------------------------------------------------
module fdp_front import fdp_pkg::*; (
  fdp_in_if.sink    in_ch,
  input  logic      full,
  output logic      push,
  output fdp_elem_t push_data
);

  fp8_dec_t               dq;
  fp8_dec_t               dk;
  logic [2*MAG_W-1:0]     mm;
  logic [SHIFT_W-1:0]     sh;

  assign dq = fp8_decode(in_ch.q_byte);
  assign dk = fp8_decode(in_ch.k_byte);
  assign mm = dq.mag * dk.mag;
  assign sh = SHIFT_W'(dq.ex) + SHIFT_W'(dk.ex) - EXP_OFFSET;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  always_comb begin
    push_data.last = in_ch.last_element;
    if (dq.neg ^ dk.neg) begin
      push_data.prod = '0;
    end else begin
      push_data.prod = PROD_W'(mm) << sh;
    end
  end

endmodule

/* rtl/fdp_fifo.sv */
// ----------------------------------------------------------------------------
// fdp_fifo
// Short element queue between the decode front and the accumulate back.
// ----------------------------------------------------------------------------
module fdp_fifo import fdp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  fdp_elem_t push_data,
  output logic      full,
  input  logic      pop,
  output fdp_elem_t pop_data,
  output logic      not_empty
);

  fdp_elem_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;

  assign full      = (count == FIFO_CW'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("fdp_fifo: push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("fdp_fifo: pop while empty");

endmodule

/* rtl/fdp_back.sv */
// ----------------------------------------------------------------------------
// fdp_back
// Saturating accumulator, two-part scale multiply and the score register.
// ----------------------------------------------------------------------------
module fdp_back import fdp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [SCALE_W-1:0] cfg_wdata,
  input  fdp_elem_t          pop_data,
  input  logic               not_empty,
  output logic               pop,
  fdp_out_if.source          out_ch
);

  fdp_state_t            state;
  fdp_state_t            state_next;
  logic [SCALE_W-1:0]    score_scale;
  logic [ACC_W-1:0]      acc;
  logic [ACC_W-1:0]      acc_sum;
  logic [ACC_W:0]        acc_wide;
  logic [ACC_W-1:0]      opnd;
  logic [PART_W-1:0]     part_hi;
  logic [PART_W-1:0]     part_lo;
  logic [FULL_W-1:0]     full_prod;
  logic                  out_valid;
  logic [SCORE_W-1:0]    score;

  assign pop      = (state == ST_ACC) && not_empty;
  assign acc_wide = {1'b0, acc} + (ACC_W + 1)'(pop_data.prod);
  assign acc_sum  = acc_wide[ACC_W] ? '1 : acc_wide[ACC_W-1:0];
  assign full_prod = {part_hi, {SCALE_LO_W{1'b0}}} + FULL_W'(part_lo);

  assign out_ch.valid = out_valid;
  assign out_ch.score = score;

  always_comb begin
    state_next = state;
    case (state)
      ST_ACC: if (pop && pop_data.last) state_next = ST_MUL;
      ST_MUL: state_next = ST_ADD;
      ST_ADD: state_next = ST_OUT;
      ST_OUT: if (out_ch.ready) state_next = ST_ACC;
      default: state_next = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_ACC;
      score_scale <= SCALE_RESET;
      acc         <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        score_scale <= cfg_wdata;
      end
      if (pop) begin
        acc <= pop_data.last ? '0 : acc_sum;
      end
      if (state == ST_ADD) begin
        out_valid <= 1'b1;
      end else if (state == ST_OUT && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_data.last) begin
      opnd <= acc_sum;
    end
    if (state == ST_MUL) begin
      part_hi <= opnd * score_scale[SCALE_W-1:SCALE_LO_W];
      part_lo <= opnd * score_scale[SCALE_LO_W-1:0];
    end
    if (state == ST_ADD) begin
      score <= full_prod[FULL_W-1:FRAC_W];
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
      pop && pop_data.last |=> state == ST_MUL && acc == '0)
    else $error("fdp_back: last element did not clear the accumulator");
  a_mul_then_add: assert property (@(posedge clk) disable iff (rst)
      state == ST_MUL |=> state == ST_ADD && !out_valid)
    else $error("fdp_back: multiply step not followed by add step");
  a_valid_in_out: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> state == ST_OUT && !pop)
    else $error("fdp_back: score presented outside output state");

endmodule

/* rtl/fp8_relu_dot_product_core.sv */
// ----------------------------------------------------------------------------
// fp8_relu_dot_product_core
// FP8 E4M3 ReLU dot product with Q8.16 output scaling.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one q/k FP8 E4M3 pair per transfer; last_element closes a vector.
//   out_ch : one 52-bit score (LSB 2^-18) per vector, after its last element.
//   cfg_wen/cfg_wdata : writes score_scale (Q8.16); write only while idle.
// Timing:
//   A transfer is decoded and multiplied in its own cycle and queued in a
//   four-entry queue; the accumulator takes one element per cycle while in
//   its accumulate state, and takes none from a vector's last element until
//   that vector's score transfer. After the last element is taken, the score
//   is formed in registered steps: the accumulate, the two 44x12 partial products, then the add.
//   The accumulator is held through these steps and until the score transfer,
//   during which the queue keeps taking elements until it fills.
// Reset: clears the queue, the accumulator and the output; scale = 1.0.
// A stalled out_ch holds the score and back-pressures in_ch once full.
// ----------------------------------------------------------------------------
module fp8_relu_dot_product_core import fdp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  fdp_in_if.sink             in_ch,
  fdp_out_if.source          out_ch,
  input  logic               cfg_wen,
  input  logic [SCALE_W-1:0] cfg_wdata
);

  logic      full;
  logic      push;
  fdp_elem_t push_data;
  logic      pop;
  fdp_elem_t pop_data;
  logic      not_empty;

  fdp_front u_front (
    .in_ch     (in_ch),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  fdp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  fdp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .pop_data  (pop_data),
    .not_empty (not_empty),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for fp8_relu_dot_product_core. Vectors of FP8 E4M3
// pairs are streamed with random gaps on both channels. Each score is
// predicted from an exact fixed-point model of the ReLU accumulation and
// the Q8.16 scaling, then compared with the score transfer. The run covers
// reset scale, zero, unity LSB, full-scale and random scales, and
// saturating vectors.
// ----------------------------------------------------------------------------
module tb_top;
  import fdp_pkg::*;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 10;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef struct packed {
    logic [FP8_W-1:0] q;
    logic [FP8_W-1:0] k;
    logic             last;
  } pair_t;

  logic               clk;
  logic               rst;
  logic               cfg_wen;
  logic [SCALE_W-1:0] cfg_wdata;

  fdp_in_if  in_ch ();
  fdp_out_if out_ch ();

  fp8_relu_dot_product_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  pair_t              pair_q[$];
  logic [SCORE_W-1:0] score_q[$];
  logic [ACC_W-1:0]   relu_acc;
  logic [SCALE_W-1:0] scale_now;
  bit                 pair_taken;
  bit                 steady;
  int                 cycles;
  int                 err_count;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.q_byte = '0;
    in_ch.k_byte = '0;
    in_ch.last_element = 1'b0;
    out_ch.ready = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [PROD_W-1:0] pair_product(input logic [FP8_W-1:0] q,
                                                     input logic [FP8_W-1:0] k);
    logic [PROD_W-1:0] mq, mk, p;
    int eq, ek;
    if (q[6:3] == 4'd0) begin
      mq = PROD_W'(q[2:0]);
      eq = 1;
    end else begin
      mq = PROD_W'({1'b1, q[2:0]});
      eq = int'(q[6:3]);
    end
    if (k[6:3] == 4'd0) begin
      mk = PROD_W'(k[2:0]);
      ek = 1;
    end else begin
      mk = PROD_W'({1'b1, k[2:0]});
      ek = int'(k[6:3]);
    end
    p = (mq * mk) << (eq + ek - 2);
    if (q[7] ^ k[7])
      p = '0;
    return p;
  endfunction

  task automatic take_pair(input logic [FP8_W-1:0] q, input logic [FP8_W-1:0] k,
                           input logic last);
    logic [ACC_W:0]    sum;
    logic [FULL_W-1:0] full;
    sum = {1'b0, relu_acc} + (ACC_W+1)'(pair_product(q, k));
    relu_acc = (sum > {1'b0, ACC_MAX}) ? ACC_MAX : sum[ACC_W-1:0];
    if (last) begin
      full = FULL_W'(relu_acc) * FULL_W'(scale_now);
      score_q.push_back(full[FULL_W-1:FRAC_W]);
      relu_acc = '0;
    end
  endtask

  // driver: one pending pair presented at a time, held until its transfer
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || pair_taken) begin
      pair_taken = 1'b0;
      if (pair_q.size() != 0 && (steady || $urandom_range(0, 99) >= 23)) begin
        in_ch.valid        <= 1'b1;
        in_ch.q_byte       <= pair_q[0].q;
        in_ch.k_byte       <= pair_q[0].k;
        in_ch.last_element <= pair_q[0].last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 23);
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
    if (!rst && in_ch.valid && in_ch.ready) begin
      take_pair(in_ch.q_byte, in_ch.k_byte, in_ch.last_element);
      pair_q.pop_front();
      pair_taken = 1'b1;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (score_q.size() == 0) begin
        $display("%0t: unexpected score transfer: expected none, actual %0d",
                 $time, out_ch.score);
        err_count++;
      end else begin
        if (out_ch.score !== score_q[0]) begin
          $display("%0t: score mismatch: expected %0d, actual %0d",
                   $time, score_q[0], out_ch.score);
          err_count++;
        end
        score_q.pop_front();
      end
    end
  end

  task automatic push_pair(input logic [FP8_W-1:0] q, input logic [FP8_W-1:0] k,
                           input logic last);
    pair_t p;
    p.q = q;
    p.k = k;
    p.last = last;
    pair_q.push_back(p);
  endtask

  task automatic push_vector(input int len, input bit sat);
    logic [FP8_W-1:0] q, k;
    logic sgn;
    for (int i = 0; i < len; i++) begin
      if (sat && $urandom_range(0, 19) != 0) begin
        sgn = 1'($urandom_range(0, 1));
        q = {sgn, 7'h7F};
        k = {sgn, 7'h7F};
      end else begin
        q = FP8_W'($urandom_range(0, 255));
        k = FP8_W'($urandom_range(0, 255));
      end
      push_pair(q, k, i == len - 1);
    end
  endtask

  task automatic push_random(input int n_pairs);
    int n;
    int len;
    n = 0;
    while (n < n_pairs) begin
      if ($urandom_range(0, 99) < 10) begin
        push_pair(FP8_W'($urandom_range(0, 255)), FP8_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        n++;
      end else if ($urandom_range(0, 99) < 90) begin
        len = int'($urandom_range(1, 12));
        push_vector(len, 1'b0);
        n += len;
      end else begin
        len = int'($urandom_range(13, 256));
        push_vector(len, 1'b0);
        n += len;
      end
    end
    // close the vector so the accumulator is clear before a scale change
    push_vector(1, 1'b0);
  endtask

  task automatic wait_drained;
    while (pair_q.size() != 0 || score_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    scale_now = v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    relu_acc = '0;
    scale_now = SCALE_RESET;
    steady = 1'b0;
    pair_taken = 1'b0;
    cycles = 0;
    err_count = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, signed zero, negative products, subnormals, exp 15
    push_pair(8'h00, 8'h00, 1'b1);
    push_pair(8'h7F, 8'h7F, 1'b1);
    push_pair(8'hFF, 8'hFF, 1'b1);
    push_pair(8'h80, 8'h7F, 1'b1);
    push_pair(8'h80, 8'h80, 1'b1);
    push_pair(8'hFF, 8'h7F, 1'b1);
    push_pair(8'h7F, 8'hC0, 1'b1);
    push_pair(8'h01, 8'h01, 1'b1);
    push_pair(8'h07, 8'h08, 1'b1);
    push_pair(8'h81, 8'h87, 1'b1);
    push_pair(8'h78, 8'h78, 1'b1);
    push_pair(8'h38, 8'h38, 1'b0);
    push_pair(8'hB8, 8'h38, 1'b0);
    push_pair(8'h55, 8'h2A, 1'b0);
    push_pair(8'hAA, 8'hD5, 1'b1);
    push_pair(8'h08, 8'h01, 1'b0);
    push_pair(8'h80, 8'h00, 1'b0);
    push_pair(8'h7F, 8'h7F, 1'b1);
    wait_drained();

    write_scale('0);
    push_random(100);
    wait_drained();

    write_scale({SCALE_W{1'b1}});
    push_vector(320, 1'b1);
    push_random(150);
    wait_drained();

    write_scale(SCALE_W'(1));
    push_random(100);
    wait_drained();

    write_scale(SCALE_RESET);
    steady = 1'b1;
    push_random(200);
    wait_drained();
    steady = 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      write_scale(SCALE_W'($urandom_range(0, (1 << SCALE_W) - 1)));
      if (ph == 1)
        push_vector(300, 1'b1);
      push_random(100);
      wait_drained();
    end

    if (score_q.size() != 0)
      err_count++;
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
